### hw/rtl/kvll_pkg.sv
// ----------------------------------------------------------------------------
// kvll_pkg: shared definitions for the key/value line lookup
// Byte codes, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package kvll_pkg;

  // default sizes
  localparam int KEY_BYTES_DEF = 32;
  localparam int MAX_VALUE_DEF = 64;

  // register file layout
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 6;
  localparam int KEY_WORDS   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd1;

  // special bytes
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // result status
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ERROR   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

### hw/rtl/kvll_item_if.sv
// ----------------------------------------------------------------------------
// kvll_item_if: input byte channel
// One file byte per item plus start, end and error flags.
// ----------------------------------------------------------------------------
interface kvll_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_file;
  logic       end_of_file;
  logic       read_error;

  modport source (output valid, data_byte, first_of_file, end_of_file, read_error,
                  input ready);
  modport sink   (input valid, data_byte, first_of_file, end_of_file, read_error,
                  output ready);
endinterface

### hw/rtl/kvll_result_if.sv
// ----------------------------------------------------------------------------
// kvll_result_if: result channel
// Value bytes and the final status of a search.
// ----------------------------------------------------------------------------
interface kvll_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       value_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, value_byte, value_valid, last, status, input ready);
  modport sink   (input valid, value_byte, value_valid, last, status, output ready);
endinterface

### hw/rtl/kvll_cfg_if.sv
// ----------------------------------------------------------------------------
// kvll_cfg_if: register write channel
// Register index and 64-bit write data.
// ----------------------------------------------------------------------------
interface kvll_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### hw/rtl/kvll_key_store.sv
// ----------------------------------------------------------------------------
// kvll_key_store: key registers
// Holds key length and key bytes, gives the clamped length and one key byte.
// ----------------------------------------------------------------------------
module kvll_key_store #(
  parameter int KEY_BYTES = kvll_pkg::KEY_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [kvll_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [kvll_pkg::CFG_DATA_W-1:0]     wr_data,
  input  logic [$clog2(KEY_BYTES+1)-1:0]      rd_idx,
  output logic [$clog2(KEY_BYTES+1)-1:0]      key_len,
  output logic [7:0]                          key_byte
);
  import kvll_pkg::*;

  localparam int KIDX_W  = $clog2(KEY_BYTES + 1);
  localparam int KADDR_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [KEY_LEN_W-1:0] key_length;
  logic [7:0]           key_mem [KEY_BYTES];

  // register writes; key byte b lives in word b/8 at bits 8*(b%8)
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
        key_mem[b] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_KEY_LENGTH) begin
        key_length <= wr_data[KEY_LEN_W-1:0];
      end
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (wr_index == REG_KEY_WORD_0 + CFG_INDEX_W'(b / 8)) begin
          key_mem[b] <= wr_data[8*(b%8) +: 8];
        end
      end
    end
  end

  // lengths above the store size count as the full store
  assign key_len = (key_length > KEY_LEN_W'(KEY_BYTES)) ? KIDX_W'(KEY_BYTES)
                                                        : KIDX_W'(key_length);

  // key byte at the match position
  assign key_byte = (rd_idx < KIDX_W'(KEY_BYTES)) ? key_mem[rd_idx[KADDR_W-1:0]] : 8'h00;

endmodule

### hw/rtl/key_value_line_lookup.sv
// ----------------------------------------------------------------------------
// key_value_line_lookup: key=value line search on a byte stream
// Matches the configured key at line start, then returns its value bytes.
// ----------------------------------------------------------------------------
// Timing: a result is registered and shown in the cycle after the item that causes it is accepted.
// Throughput: 1 item per cycle while results are taken; the one-deep result
//   register sets this, the byte compare and mode update are combinational.
// Reset (rst, synchronous): search back at line start, counters and key
//   registers zero, result register empty.
module key_value_line_lookup #(
  parameter int KEY_BYTES = kvll_pkg::KEY_BYTES_DEF,
  parameter int MAX_VALUE = kvll_pkg::MAX_VALUE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  kvll_item_if.sink     item,
  kvll_result_if.source result,
  kvll_cfg_if.sink      cfg
);
  import kvll_pkg::*;

  localparam int KIDX_W = $clog2(KEY_BYTES + 1);
  localparam int VCNT_W = $clog2(MAX_VALUE + 1);

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_SKIP,
    MODE_VALUE,
    MODE_DONE
  } mode_t;

  // search state
  mode_t             scan_mode, scan_mode_next;
  logic [KIDX_W-1:0] key_index, key_index_next;
  logic [VCNT_W-1:0] value_count, value_count_next;

  // result register
  logic    res_valid;
  logic [7:0] res_byte;
  logic    res_value_valid;
  logic    res_last;
  status_t res_status;

  // working values
  mode_t             mode_cur;
  logic [KIDX_W-1:0] kidx_cur;
  logic [VCNT_W-1:0] vcnt_cur, vcnt_inc;
  logic [KIDX_W-1:0] key_len;
  logic [7:0]        key_byte;
  logic              is_nl, is_eq;
  logic              emit;
  logic [7:0]        e_byte;
  logic              e_value_valid;
  logic              e_last;
  status_t           e_status;
  logic              item_acc;

  // key registers
  kvll_key_store #(.KEY_BYTES(KEY_BYTES)) u_key_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.reg_index),
    .wr_data  (cfg.wr_data),
    .rd_idx   (kidx_cur),
    .key_len  (key_len),
    .key_byte (key_byte)
  );

  assign cfg.ready  = 1'b1;
  assign item.ready = !res_valid || result.ready;
  assign item_acc   = item.valid && item.ready;

  // one item: restart, then finished search, empty key, error, end of file, data byte
  always_comb begin
    mode_cur = item.first_of_file ? MODE_MATCH : scan_mode;
    kidx_cur = item.first_of_file ? '0 : key_index;
    vcnt_cur = item.first_of_file ? '0 : value_count;
    vcnt_inc = vcnt_cur + 1'b1;
    is_nl    = (item.data_byte == CH_NEWLINE);
    is_eq    = (item.data_byte == CH_EQUAL);

    scan_mode_next   = mode_cur;
    key_index_next   = kidx_cur;
    value_count_next = vcnt_cur;
    emit             = 1'b0;
    e_byte           = 8'h00;
    e_value_valid    = 1'b0;
    e_last           = 1'b0;
    e_status         = ST_FOUND;

    if (mode_cur == MODE_DONE) begin
      emit = 1'b0;
    end else if (mode_cur != MODE_VALUE && key_len == '0) begin
      emit     = 1'b1;
      e_last   = 1'b1;
      e_status = ST_EMPTY;
    end else if (item.read_error) begin
      emit     = 1'b1;
      e_last   = 1'b1;
      e_status = ST_ERROR;
    end else if (mode_cur == MODE_VALUE) begin
      emit = 1'b1;
      if (item.end_of_file || is_nl) begin
        e_last = 1'b1;
      end else begin
        value_count_next = vcnt_inc;
        e_byte           = item.data_byte;
        e_value_valid    = 1'b1;
        e_last           = (vcnt_inc >= VCNT_W'(MAX_VALUE));
      end
    end else if (item.end_of_file) begin
      emit     = 1'b1;
      e_last   = 1'b1;
      e_status = ST_MISSING;
    end else if (mode_cur == MODE_SKIP) begin
      if (is_nl) begin
        scan_mode_next = MODE_MATCH;
        key_index_next = '0;
      end
    end else if (kidx_cur >= key_len) begin
      // whole key seen: '=' opens the value
      if (is_eq) begin
        scan_mode_next   = MODE_VALUE;
        value_count_next = '0;
      end else if (is_nl) begin
        key_index_next = '0;
      end else begin
        scan_mode_next = MODE_SKIP;
      end
    end else if (item.data_byte == key_byte) begin
      key_index_next = kidx_cur + 1'b1;
    end else if (is_nl) begin
      key_index_next = '0;
    end else begin
      scan_mode_next = MODE_SKIP;
    end

    if (emit && e_last) begin
      scan_mode_next = MODE_DONE;
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_MATCH;
      key_index   <= '0;
      value_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (item_acc) begin
        scan_mode   <= scan_mode_next;
        key_index   <= key_index_next;
        value_count <= value_count_next;
      end
      if (item_acc && emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_acc && emit) begin
      res_byte        <= e_byte;
      res_value_valid <= e_value_valid;
      res_last        <= e_last;
      res_status      <= e_status;
    end
  end

  assign result.valid       = res_valid;
  assign result.value_byte  = res_byte;
  assign result.value_valid = res_value_valid;
  assign result.last        = res_last;
  assign result.status      = res_status;

endmodule

### hw/rtl/kvll_checker.sv
// ----------------------------------------------------------------------------
// kvll_checker: port checks for the key/value line lookup
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module kvll_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] value_byte,
  input logic       value_valid,
  input logic       last,
  input logic [1:0] status
);
  import kvll_pkg::*;

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({value_byte, value_valid, last, status}))
    else $error("stalled result changed");

  // value bytes only come with found status
  a_value_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_valid |-> status == ST_FOUND)
    else $error("value byte with non-found status");

  // every result without a value byte closes the search
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_valid |-> last)
    else $error("status result not marked last");

endmodule

bind key_value_line_lookup kvll_checker u_kvll_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .value_byte  (result.value_byte),
  .value_valid (result.value_valid),
  .last        (result.last),
  .status      (result.status)
);

### verif/key_value_line_lookup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_line_lookup_test: self-checking bench for the key=value lookup
// Streams files of key=value lines, some well formed and some broken, through
// the item channel under several key settings and idle patterns. A scoreboard
// tracks the search state, predicts each value byte and status, and checks
// every result item against it in order.
// ----------------------------------------------------------------------------
module key_value_line_lookup_test;
  import kvll_pkg::*;

  localparam int KEY_BYTES     = KEY_BYTES_DEF;
  localparam int MAX_VALUE     = MAX_VALUE_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_KEY = 65;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       end_of_file;
    logic       read_error;
  } file_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       last;
    status_t    status;
  } lookup_result_t;

  typedef enum logic [1:0] {SCAN_MATCH, SCAN_SKIP, SCAN_VALUE, SCAN_DONE} scan_state_t;
  typedef enum {KEY_LETTERS, KEY_ANY, KEY_ONES, KEY_ZEROS} key_kind_t;

  // scoreboard: search state, key registers and the results still owed
  class lookup_scoreboard;
    logic [5:0]     key_len;
    logic [63:0]    key_words [KEY_WORDS];
    scan_state_t    scan;
    logic [5:0]     key_idx;
    logic [6:0]     value_cnt;
    lookup_result_t expected_results [$];
    int             errors;

    function new();
      key_len = '0;
      foreach (key_words[i]) key_words[i] = '0;
      scan = SCAN_MATCH;
      key_idx = '0;
      value_cnt = '0;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
      if (idx == REG_KEY_LENGTH)
        key_len = data[KEY_LEN_W-1:0];
      else if (idx >= REG_KEY_WORD_0 && idx < REG_KEY_WORD_0 + KEY_WORDS)
        key_words[2'(idx - REG_KEY_WORD_0)] = data;
    endfunction

    // advance the search by one accepted item and queue the result it causes
    function void note_item(file_item_t it);
      int unsigned    klen;
      lookup_result_t r;
      bit             has_result;
      klen = (key_len > KEY_BYTES) ? KEY_BYTES : key_len;
      if (it.first_of_file) begin
        scan = SCAN_MATCH;
        key_idx = '0;
        value_cnt = '0;
      end
      if (scan == SCAN_DONE) return;
      has_result = 1'b1;
      r = '{value_byte: 8'h00, value_valid: 1'b0, last: 1'b1, status: ST_FOUND};
      if (scan != SCAN_VALUE && klen == 0) begin
        r.status = ST_EMPTY;
      end else if (it.read_error) begin
        r.status = ST_ERROR;
      end else if (scan == SCAN_VALUE) begin
        // newline or end of file closes the value with an empty final item
        if (!it.end_of_file && it.data_byte != CH_NEWLINE) begin
          value_cnt++;
          r.value_byte = it.data_byte;
          r.value_valid = 1'b1;
          r.last = (value_cnt >= MAX_VALUE);
        end
      end else if (it.end_of_file) begin
        r.status = ST_MISSING;
      end else begin
        has_result = 1'b0;
        if (scan == SCAN_SKIP) begin
          if (it.data_byte == CH_NEWLINE) begin
            scan = SCAN_MATCH;
            key_idx = '0;
          end
        end else if (key_idx >= klen) begin
          // whole key seen, '=' must follow
          if (it.data_byte == CH_EQUAL) begin
            scan = SCAN_VALUE;
            value_cnt = '0;
          end else if (it.data_byte == CH_NEWLINE) begin
            key_idx = '0;
          end else begin
            scan = SCAN_SKIP;
          end
        end else if (it.data_byte == key_words[key_idx[4:3]][8*key_idx[2:0] +: 8]) begin
          key_idx++;
        end else if (it.data_byte == CH_NEWLINE) begin
          key_idx = '0;
        end else begin
          scan = SCAN_SKIP;
        end
      end
      if (has_result) begin
        if (r.last) scan = SCAN_DONE;
        expected_results.push_back(r);
      end
    endfunction

    function void mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.value_byte !== want.value_byte)
        mismatch("value_byte", want.value_byte, got.value_byte);
      if (got.value_valid !== want.value_valid)
        mismatch("value_valid", 8'(want.value_valid), 8'(got.value_valid));
      if (got.last !== want.last)
        mismatch("last", 8'(want.last), 8'(got.last));
      if (got.status !== want.status)
        mismatch("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst;

  kvll_item_if   item_bus ();
  kvll_result_if result_bus ();
  kvll_cfg_if    cfg_bus ();

  key_value_line_lookup dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  lookup_scoreboard sb;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int          hold_left;
  int          stall_cycles;
  logic [5:0]  key_len_cfg;
  logic [63:0] key_cfg [KEY_WORDS];
  file_item_t  file_items [$];

  always #1 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check results, note items and register writes, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid && result_bus.ready)
        sb.check_result('{value_byte: result_bus.value_byte,
                          value_valid: result_bus.value_valid,
                          last: result_bus.last,
                          status: status_t'(result_bus.status)});
      if (item_bus.valid && item_bus.ready)
        sb.note_item('{data_byte: item_bus.data_byte,
                       first_of_file: item_bus.first_of_file,
                       end_of_file: item_bus.end_of_file,
                       read_error: item_bus.read_error});
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_register(cfg_bus.reg_index, cfg_bus.wr_data);
      if ((result_bus.valid && result_bus.ready) || (item_bus.valid && item_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic file_item_t mk(logic [7:0] b, logic first, logic eof, logic err);
    return '{data_byte: b, first_of_file: first, end_of_file: eof, read_error: err};
  endfunction

  function automatic logic [7:0] key_at(int i);
    return key_cfg[i / 8][8 * (i % 8) +: 8];
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(file_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.data_byte     <= it.data_byte;
    item_bus.first_of_file <= it.first_of_file;
    item_bus.end_of_file   <= it.end_of_file;
    item_bus.read_error    <= it.read_error;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  task automatic send_text(string s, bit first);
    for (int i = 0; i < s.len(); i++)
      send_item(mk(s[i], first && i == 0, 1'b0, 1'b0));
  endtask

  // stop offering, let every owed result drain, then cover the pipeline
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic write_key(logic [5:0] len, logic [63:0] w0, logic [63:0] w1,
                           logic [63:0] w2, logic [63:0] w3);
    key_len_cfg = len;
    key_cfg[0] = w0;
    key_cfg[1] = w1;
    key_cfg[2] = w2;
    key_cfg[3] = w3;
    write_reg(REG_KEY_LENGTH, {58'd0, len});
    for (int i = 0; i < KEY_WORDS; i++)
      write_reg(REG_KEY_WORD_0 + CFG_INDEX_W'(i), key_cfg[i]);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic configure(logic [5:0] len, key_kind_t kind);
    logic [63:0] w [KEY_WORDS];
    int          used;
    used = (len > KEY_BYTES) ? KEY_BYTES : len;
    foreach (w[i]) w[i] = (kind == KEY_ONES) ? '1 : '0;
    if (kind == KEY_ANY) begin
      foreach (w[i]) w[i] = {$urandom, $urandom};
    end else if (kind == KEY_LETTERS) begin
      for (int i = 0; i < used; i++)
        w[i / 8][8 * (i % 8) +: 8] = 8'h61 + 8'($urandom_range(25));
    end
    write_key(len, w[0], w[1], w[2], w[3]);
  endtask

  function automatic void push_byte(logic [7:0] b);
    file_items.push_back(mk(b, 1'b0, 1'b0, 1'b0));
  endfunction

  function automatic void push_key(int n);
    for (int i = 0; i < n; i++) push_byte(key_at(i));
  endfunction

  function automatic void push_value(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
  endfunction

  // one file of mostly well-formed lines; the key line tends to come last
  function automatic void build_file(bit long_value);
    int klen;
    int nlines;
    int kind;
    int vlen;
    klen = (key_len_cfg > KEY_BYTES) ? KEY_BYTES : key_len_cfg;
    nlines = $urandom_range(1, 4);
    file_items.delete();
    for (int l = 0; l < nlines; l++) begin
      kind = $urandom_range(1, 7);
      if (long_value || (l == nlines - 1 && $urandom_range(3) != 0)) kind = 0;
      vlen = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 8);
      if (long_value) vlen = 100;
      case (kind)
        0: begin
          // the key line, sometimes cut short by the file end
          push_key(klen);
          push_byte(CH_EQUAL);
          push_value(vlen);
          if ($urandom_range(3) != 0) push_byte(CH_NEWLINE);
        end
        1: begin
          // longer key sharing the configured one as prefix
          push_key(klen);
          push_byte(8'h61 + 8'($urandom_range(25)));
          push_byte(CH_EQUAL);
          push_value(vlen);
          push_byte(CH_NEWLINE);
        end
        2: begin
          push_key((klen > 0) ? $urandom_range(klen - 1) : 0);
          push_byte(CH_NEWLINE);
        end
        3: begin
          push_key(klen);
          push_byte(CH_NEWLINE);
        end
        4: begin
          for (int i = $urandom_range(10); i > 0; i--)
            push_byte(($urandom_range(5) == 0) ? CH_EQUAL : 8'h61 + 8'($urandom_range(25)));
          push_byte(CH_NEWLINE);
        end
        5: push_byte(CH_NEWLINE);
        default: begin
          // key with one wrong byte inside
          push_key(klen);
          if (klen > 0) file_items[file_items.size() - 1 - $urandom_range(klen - 1)].data_byte ^=
              8'h01 << $urandom_range(7);
          push_byte(CH_EQUAL);
          push_value(vlen);
          push_byte(CH_NEWLINE);
        end
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: file_items.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0));
      5, 6: file_items.push_back(mk(8'($urandom_range(255)), 1'b0,
                                    1'($urandom_range(1)), 1'b1));
      default: ;
    endcase
    // light noise on a few items
    if (!long_value) begin
      foreach (file_items[i]) begin
        if ($urandom_range(99) < 4) file_items[i].data_byte = 8'($urandom_range(255));
        if ($urandom_range(99) < 2) file_items[i].read_error = 1'b1;
        if ($urandom_range(99) < 2) file_items[i].end_of_file = 1'b1;
        if ($urandom_range(99) < 2) file_items[i].first_of_file = 1'b1;
      end
    end
    file_items[0].first_of_file = 1'b1;
  endfunction

  task automatic run_files(int target, bit pressure);
    int sent;
    int files;
    sent = 0;
    files = 0;
    while (sent < target) begin
      // long hold-off on the result side while a long value streams in
      if (pressure && files == 0) hold_request = 1'b1;
      build_file(pressure && files == 0);
      foreach (file_items[i]) send_item(file_items[i]);
      sent += file_items.size();
      files++;
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 65;
    hold_request = 1'b0;
    hold_left = 0;
    stall_cycles = 0;
    key_len_cfg = '0;
    foreach (key_cfg[i]) key_cfg[i] = '0;
    item_bus.valid = 1'b0;
    item_bus.data_byte = '0;
    item_bus.first_of_file = 1'b0;
    item_bus.end_of_file = 1'b0;
    item_bus.read_error = 1'b0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = '0;
    cfg_bus.wr_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: key "ab"
    write_key(6'd2, 64'h6261, '0, '0, '0);
    send_text("abb=\n", 1'b1);            // longer key with the same prefix
    send_text("a\n", 1'b0);               // newline where a key byte is due
    send_text("ab\n", 1'b0);              // newline where '=' is due
    send_text("ab=", 1'b0);
    send_item(mk(8'h00, 1'b0, 1'b0, 1'b0));
    send_item(mk(8'hFF, 1'b0, 1'b0, 1'b0));
    send_item(mk(8'h5A, 1'b0, 1'b1, 1'b0)); // end of file inside the value
    send_text("x", 1'b0);                 // search over, ignored
    send_item(mk(8'h00, 1'b1, 1'b1, 1'b0)); // end of file while searching
    send_item(mk(8'hA5, 1'b1, 1'b1, 1'b1)); // error wins over end of file
    send_text("ab=\n", 1'b1);             // empty value
    wait_drained();

    // empty key
    write_key(6'd0, 64'h6261, '0, '0, '0);
    send_text("a", 1'b1);
    wait_drained();

    // key length cut mid-search: '=' now due right after "a"
    write_key(6'd2, 64'h6261, '0, '0, '0);
    send_text("a", 1'b1);
    wait_drained();
    write_reg(REG_KEY_LENGTH, 64'd1);
    cfg_bus.valid <= 1'b0;
    key_len_cfg = 6'd1;
    send_text("=Z", 1'b0);
    send_item(mk(8'h00, 1'b0, 1'b1, 1'b0));
    wait_drained();

    // random files, sender idles a little, receiver a lot
    configure(6'd3, KEY_LETTERS);
    run_files(ITEMS_PER_KEY, 1'b0);
    configure(6'd1, KEY_LETTERS);
    run_files(ITEMS_PER_KEY, 1'b0);

    // sender idles a lot, receiver a little
    send_idle_pct = 65;
    recv_idle_pct = 15;
    configure(6'd32, KEY_LETTERS);
    run_files(ITEMS_PER_KEY, 1'b0);
    configure(6'd63, KEY_ANY);            // longer than the key store
    run_files(ITEMS_PER_KEY, 1'b0);

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(6'd0, KEY_ANY);
    run_files(ITEMS_PER_KEY, 1'b0);
    configure(6'd5, KEY_LETTERS);
    run_files(ITEMS_PER_KEY, 1'b1);
    configure(6'd8, KEY_ONES);
    run_files(ITEMS_PER_KEY, 1'b0);
    configure(6'd2, KEY_ZEROS);
    run_files(ITEMS_PER_KEY, 1'b0);

    repeat (5) @(posedge clk);
    if (sb.expected_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_results.size());
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/kvll_pkg.sv
hw/rtl/kvll_item_if.sv
hw/rtl/kvll_result_if.sv
hw/rtl/kvll_cfg_if.sv
hw/rtl/kvll_key_store.sv
hw/rtl/key_value_line_lookup.sv
hw/rtl/kvll_checker.sv
verif/key_value_line_lookup_test.sv
